// File: design/bounded_indexed_list_top_defines.svh
// assertion macros for the bounded indexed list checker
// no dependencies; included by the checker file only
`ifndef BOUNDED_INDEXED_LIST_TOP_DEFINES_SVH
`define BOUNDED_INDEXED_LIST_TOP_DEFINES_SVH

// same-cycle implication
`define BIL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded indexed list check failed");

// next-cycle implication
`define BIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded indexed list check failed");

`endif

// File: design/bil_pkg.sv
// shared types and constants for the bounded indexed list
// no dependencies; used by the controller, datapath and top level
package bil_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int KIND_W         = 3;
  localparam int POS_W          = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_GET    = 3'd2,
    KIND_SET    = 3'd3,
    KIND_NEXT   = 3'd4,
    KIND_REWIND = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CAPTURE,
    ST_SHIFT_UP,
    ST_SHIFT_DOWN,
    ST_WRITE,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_ITEM,
    RD_UP,
    RD_DOWN
  } rd_src_t;

  typedef struct packed {
    logic    latch;
    rd_src_t rd_src;
    logic    capture;
    logic    wr_word;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic next_ok;
    logic op_remove;
    logic up_more;
    logic down_more;
  } stat_t;

endpackage

// File: design/bil_ctrl.sv
// controller state machine for the bounded indexed list
// depends on bil_pkg; drives the datapath through cmd_t, watches stat_t
module bil_ctrl import bil_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KIND_W-1:0] kind,
  input  stat_t             stat,
  output logic              busy,
  output cmd_t              cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (kind_t'(kind))
            KIND_INSERT: state_nxt = stat.full ? ST_FINISH : ST_SHIFT_UP;
            KIND_REMOVE,
            KIND_GET:    state_nxt = stat.empty ? ST_FINISH : ST_READ;
            KIND_SET:    state_nxt = stat.empty ? ST_FINISH : ST_WRITE;
            KIND_NEXT:   state_nxt = stat.next_ok ? ST_READ : ST_FINISH;
            default:     state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_READ:       state_nxt = ST_CAPTURE;
      ST_CAPTURE:    state_nxt = stat.op_remove ? ST_SHIFT_DOWN : ST_FINISH;
      ST_SHIFT_UP:   state_nxt = stat.up_more ? ST_SHIFT_UP : ST_WRITE;
      ST_SHIFT_DOWN: state_nxt = stat.down_more ? ST_SHIFT_DOWN : ST_FINISH;
      ST_WRITE:      state_nxt = ST_FINISH;
      ST_FINISH:     state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state_r != ST_IDLE);
    cmd.latch   = (state_r == ST_IDLE) && start;
    cmd.capture = (state_r == ST_CAPTURE);
    cmd.wr_word = (state_r == ST_WRITE);
    cmd.finish  = (state_r == ST_FINISH);
    cmd.rd_src  = RD_NONE;
    unique case (state_r)
      ST_READ:       cmd.rd_src = RD_ITEM;
      ST_SHIFT_UP:   cmd.rd_src = stat.up_more ? RD_UP : RD_NONE;
      ST_SHIFT_DOWN: cmd.rd_src = stat.down_more ? RD_DOWN : RD_NONE;
      default:       cmd.rd_src = RD_NONE;
    endcase
  end

endmodule

// File: design/bil_dpath.sv
// datapath for the bounded indexed list: entry memory, count, cursor, results
// depends on bil_pkg; sequenced by bil_ctrl through cmd_t
module bil_dpath import bil_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic signed [POS_W-1:0] in_position,
  input  logic [WORD_WIDTH-1:0]   in_entry_word,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  output logic                    out_valid,
  output logic [WORD_WIDTH-1:0]   out_read_word,
  output logic                    out_fault,
  output logic [CW-1:0]           out_count_now
);

  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [WORD_WIDTH-1:0] mem [CAPACITY];

  kind_t                 kind_r;
  logic [WORD_WIDTH-1:0] word_r;
  logic [AW-1:0]         idx_r;
  logic [CW-1:0]         ptr_r, ptr_nxt;
  logic [WORD_WIDTH-1:0] rdata_r;
  logic [WORD_WIDTH-1:0] hold_r;
  logic                  pend_r;
  logic [AW-1:0]         pend_addr_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         cur_pos_r, cur_pos_nxt;
  logic                  cur_valid_r, cur_valid_nxt;
  logic                  out_valid_r;
  logic [WORD_WIDTH-1:0] out_word_r, out_word_nxt;
  logic                  out_fault_r, out_fault_nxt;
  logic [CW-1:0]         out_count_r;

  // index clamping
  logic          pos_le0;
  logic [PW-1:0] pos_x, cnt_x, cnt_m1_x, ins_idx_x, last_idx_x;
  logic [AW-1:0] idx_nxt;

  always_comb begin
    pos_le0    = in_position[POS_W-1] || (in_position == '0);
    pos_x      = pos_le0 ? '0 : {{(PW-POS_W+1){1'b0}}, in_position[POS_W-2:0]};
    cnt_x      = {{(PW-CW){1'b0}}, count_r};
    cnt_m1_x   = cnt_x - PW'(1);
    ins_idx_x  = (pos_x >= cnt_x) ? cnt_x : pos_x;
    last_idx_x = (pos_x >= cnt_m1_x) ? cnt_m1_x : pos_x;
    idx_nxt    = (kind_t'(in_kind) == KIND_INSERT) ? ins_idx_x[AW-1:0] : last_idx_x[AW-1:0];
  end

  // status
  logic [CW-1:0] cur_pos_x, idx_x;
  logic [CW:0]   ptr_p1_x, cur_p1_x;

  always_comb begin
    cur_pos_x      = {{(CW-AW){1'b0}}, cur_pos_r};
    idx_x          = {{(CW-AW){1'b0}}, idx_r};
    ptr_p1_x       = {1'b0, ptr_r} + (CW+1)'(1);
    cur_p1_x       = {1'b0, cur_pos_x} + (CW+1)'(1);
    stat.full      = (count_r == CW'(CAPACITY));
    stat.empty     = (count_r == '0);
    stat.next_ok   = cur_valid_r && (cur_pos_x < count_r);
    stat.op_remove = (kind_r == KIND_REMOVE);
    stat.up_more   = (ptr_r > idx_x);
    stat.down_more = (ptr_p1_x < {1'b0, count_r});
  end

  // memory ports
  logic [CW-1:0]         ptr_dec;
  logic                  rd_en;
  logic [AW-1:0]         raddr;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;

  always_comb begin
    ptr_dec = ptr_r - CW'(1);
    rd_en   = (cmd.rd_src != RD_NONE);
    unique case (cmd.rd_src)
      RD_ITEM: raddr = (kind_r == KIND_NEXT) ? cur_pos_r : idx_r;
      RD_UP:   raddr = ptr_dec[AW-1:0];
      RD_DOWN: raddr = ptr_p1_x[AW-1:0];
      default: raddr = '0;
    endcase
    mem_we    = pend_r || cmd.wr_word;
    mem_waddr = pend_r ? pend_addr_r : idx_r;
    mem_wdata = pend_r ? rdata_r : word_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // shift pointer
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.latch) begin
      ptr_nxt = (kind_t'(in_kind) == KIND_INSERT) ? count_r : {{(CW-AW){1'b0}}, idx_nxt};
    end else if (cmd.rd_src == RD_UP) begin
      ptr_nxt = ptr_dec;
    end else if (cmd.rd_src == RD_DOWN) begin
      ptr_nxt = ptr_p1_x[CW-1:0];
    end
  end

  // list state update and result at the end of an operation
  always_comb begin
    count_nxt     = count_r;
    cur_pos_nxt   = cur_pos_r;
    cur_valid_nxt = cur_valid_r;
    out_word_nxt  = '0;
    out_fault_nxt = 1'b0;
    unique case (kind_r)
      KIND_INSERT: begin
        if (stat.full) begin
          out_fault_nxt = 1'b1;
        end else begin
          count_nxt = count_r + CW'(1);
          if (stat.empty) begin
            cur_pos_nxt   = '0;
            cur_valid_nxt = 1'b1;
          end else if (cur_valid_r && (idx_r <= cur_pos_r)) begin
            cur_pos_nxt = cur_pos_r + AW'(1);
          end
        end
      end
      KIND_REMOVE: begin
        if (stat.empty) begin
          out_fault_nxt = 1'b1;
        end else begin
          out_word_nxt = hold_r;
          count_nxt    = count_r - CW'(1);
          if (cur_valid_r) begin
            if (cur_pos_r == idx_r) begin
              cur_pos_nxt   = '0;
              cur_valid_nxt = (count_r != CW'(1));
            end else if (cur_pos_r > idx_r) begin
              cur_pos_nxt = cur_pos_r - AW'(1);
            end
          end
        end
      end
      KIND_GET: begin
        if (stat.empty) begin
          out_fault_nxt = 1'b1;
        end else begin
          out_word_nxt = hold_r;
        end
      end
      KIND_NEXT: begin
        if (!stat.next_ok) begin
          cur_valid_nxt = 1'b0;
          out_fault_nxt = 1'b1;
        end else begin
          out_word_nxt = hold_r;
          if (cur_p1_x < {1'b0, count_r}) begin
            cur_pos_nxt = cur_pos_r + AW'(1);
          end else begin
            cur_valid_nxt = 1'b0;
          end
        end
      end
      KIND_REWIND: begin
        cur_pos_nxt   = '0;
        cur_valid_nxt = !stat.empty;
      end
      default: begin
        out_word_nxt = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cur_pos_r   <= '0;
      cur_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      kind_r      <= KIND_INSERT;
    end else begin
      pend_r      <= (cmd.rd_src == RD_UP) || (cmd.rd_src == RD_DOWN);
      out_valid_r <= cmd.finish;
      if (cmd.latch) begin
        kind_r <= kind_t'(in_kind);
      end
      if (cmd.finish) begin
        count_r     <= count_nxt;
        cur_pos_r   <= cur_pos_nxt;
        cur_valid_r <= cur_valid_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    pend_addr_r <= ptr_r[AW-1:0];
    if (cmd.latch) begin
      word_r <= in_entry_word;
      idx_r  <= idx_nxt;
    end
    if (cmd.capture) begin
      hold_r <= rdata_r;
    end
    if (cmd.finish) begin
      out_word_r  <= out_word_nxt;
      out_fault_r <= out_fault_nxt;
      out_count_r <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_word = out_word_r;
  assign out_fault     = out_fault_r;
  assign out_count_now = out_count_r;

endmodule

// File: design/bounded_indexed_list_top.sv
// Bounded indexed list: an ordered list of up to CAPACITY words with a read
// cursor, held in a single-port-write, single-port-read memory. An operation is
// taken when start is high and busy is low; its one result appears on the out_
// ports for exactly one cycle with out_valid high and cannot be stalled. The
// length of insert and remove comes from the memory sweep that moves one entry
// per cycle. No clearing pass after reset.
// Depends on bil_pkg, bil_ctrl and bil_dpath.
module bounded_indexed_list_top import bil_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic signed [POS_W-1:0] in_position,
  input  logic [WORD_WIDTH-1:0]   in_entry_word,
  output logic                    out_valid,
  output logic [WORD_WIDTH-1:0]   out_read_word,
  output logic                    out_fault,
  output logic [CW-1:0]           out_count_now
);

  cmd_t  cmd;
  stat_t stat;

  bil_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_kind),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  bil_dpath #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_kind       (in_kind),
    .in_position   (in_position),
    .in_entry_word (in_entry_word),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_read_word (out_read_word),
    .out_fault     (out_fault),
    .out_count_now (out_count_now)
  );

endmodule

// File: design/bil_checker.sv
// port-level checks for the bounded indexed list, bound to the top level
// depends on bil_pkg and bounded_indexed_list_top_defines.svh
`include "bounded_indexed_list_top_defines.svh"

module bil_checker import bil_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [WORD_WIDTH-1:0] out_read_word,
  input logic                  out_fault,
  input logic [CW-1:0]         out_count_now
);

  // an accepted beat always makes the block busy in the next cycle
  `BIL_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // the result strobe shows only once the block is free again
  `BIL_ASSERT_IMPLY(a_strobe_idle, clk, rst_n, out_valid, !busy)
  `BIL_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `BIL_ASSERT_IMPLY(a_fault_zero, clk, rst_n, out_valid && out_fault, out_read_word == '0)
  `BIL_ASSERT_IMPLY(a_count_cap, clk, rst_n, out_valid, out_count_now <= CW'(CAPACITY))

endmodule

bind bounded_indexed_list_top bil_checker #(
  .CAPACITY   (CAPACITY),
  .WORD_WIDTH (WORD_WIDTH)
) u_bil_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_read_word (out_read_word),
  .out_fault     (out_fault),
  .out_count_now (out_count_now)
);

// File: test/bounded_indexed_list_top_tb.sv
// testbench for the bounded indexed list: directed corner operations, then
// random fill, cursor walk, churn and drain sequences checked against a shadow list
// depends on bil_pkg and bounded_indexed_list_top
module bounded_indexed_list_top_tb;
  import bil_pkg::*;

  localparam int CAP   = CAPACITY_DEF;
  localparam int WW    = WORD_WIDTH_DEF;
  localparam int CNT_W = $clog2(CAP + 1);

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  typedef struct {
    logic [WW-1:0]    word;
    logic             fault;
    logic [CNT_W-1:0] count;
  } list_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [KIND_W-1:0]       in_kind;
  logic signed [POS_W-1:0] in_position;
  logic [WW-1:0]           in_entry_word;
  logic                    out_valid;
  logic [WW-1:0]           out_read_word;
  logic                    out_fault;
  logic [CNT_W-1:0]        out_count_now;

  // shadow copy of the list
  logic [WW-1:0] shadow_entries [CAP];
  int            shadow_count;
  int            shadow_cursor;
  bit            shadow_cursor_ok;

  list_result_t pending_results[$];
  int  errors;
  int  ops_sent;
  int  beats_checked;
  int  faults_seen;
  int  full_hits;
  bit  idle_on;

  bounded_indexed_list_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_position  (in_position),
    .in_entry_word(in_entry_word),
    .out_valid    (out_valid),
    .out_read_word(out_read_word),
    .out_fault    (out_fault),
    .out_count_now(out_count_now)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int clamp_to_last(int p);
    if (p <= 0) return 0;
    if (p >= shadow_count - 1) return shadow_count - 1;
    return p;
  endfunction

  // apply one operation to the shadow list and return its result
  function automatic list_result_t shadow_list_op(logic [KIND_W-1:0] kind,
                                                  logic signed [POS_W-1:0] pos,
                                                  logic [WW-1:0] word);
    list_result_t r;
    int p;
    int idx;
    r.word  = '0;
    r.fault = 1'b0;
    p = int'(pos);
    case (kind)
      KIND_INSERT: begin
        if (shadow_count >= CAP) begin
          r.fault = 1'b1;
          full_hits++;
        end else begin
          if (p <= 0) idx = 0;
          else if (p >= shadow_count) idx = shadow_count;
          else idx = p;
          for (int i = shadow_count; i > idx; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[idx] = word;
          if (shadow_count == 0) begin
            shadow_cursor    = 0;
            shadow_cursor_ok = 1'b1;
          end else if (shadow_cursor_ok && idx <= shadow_cursor) begin
            shadow_cursor++;
          end
          shadow_count++;
        end
      end
      KIND_REMOVE: begin
        if (shadow_count == 0) begin
          r.fault = 1'b1;
        end else begin
          idx = clamp_to_last(p);
          r.word = shadow_entries[idx];
          for (int i = idx; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
          if (shadow_cursor_ok) begin
            if (shadow_cursor == idx) begin
              shadow_cursor    = 0;
              shadow_cursor_ok = shadow_count > 0;
            end else if (shadow_cursor > idx) begin
              shadow_cursor--;
            end
          end
        end
      end
      KIND_GET: begin
        if (shadow_count == 0) r.fault = 1'b1;
        else r.word = shadow_entries[clamp_to_last(p)];
      end
      KIND_SET: begin
        if (shadow_count != 0) shadow_entries[clamp_to_last(p)] = word;
      end
      KIND_NEXT: begin
        if (!shadow_cursor_ok || shadow_cursor >= shadow_count) begin
          shadow_cursor_ok = 1'b0;
          r.fault = 1'b1;
        end else begin
          r.word = shadow_entries[shadow_cursor];
          if (shadow_cursor + 1 < shadow_count) shadow_cursor++;
          else shadow_cursor_ok = 1'b0;
        end
      end
      KIND_REWIND: begin
        shadow_cursor    = 0;
        shadow_cursor_ok = shadow_count > 0;
      end
      default: ;
    endcase
    r.count = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  // one command beat, with an optional idle burst ahead of it
  task automatic send_op(logic [KIND_W-1:0] kind, logic signed [POS_W-1:0] pos,
                         logic [WW-1:0] word);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
    @(negedge clk);
    start         <= 1'b1;
    in_kind       <= kind;
    in_position   <= pos;
    in_entry_word <= word;
    do @(posedge clk); while (busy);
    pending_results.push_back(shadow_list_op(kind, pos, word));
    ops_sent++;
  endtask

  function automatic logic signed [POS_W-1:0] pick_position();
    case ($urandom_range(0, 7))
      0: return POS_W'($urandom_range(0, 255));
      1: return POS_W'(-128);
      2: return POS_W'(127);
      3: return POS_W'(-$urandom_range(1, 3));
      default: return POS_W'($urandom_range(0, shadow_count));
    endcase
  endfunction

  function automatic logic [WW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return WW'($urandom);
    endcase
  endfunction

  task automatic random_op(int insert_w, int remove_w);
    int r;
    logic [KIND_W-1:0] kind;
    r = $urandom_range(0, 99);
    if (r < insert_w) kind = KIND_INSERT;
    else if (r < insert_w + remove_w) kind = KIND_REMOVE;
    else begin
      case ($urandom_range(0, 16))
        0:       kind = KIND_SPARE_A;
        1:       kind = KIND_SPARE_B;
        2, 3:    kind = KIND_REWIND;
        4, 5, 6: kind = KIND_SET;
        7, 8, 9, 10: kind = KIND_GET;
        default: kind = KIND_NEXT;
      endcase
    end
    send_op(kind, pick_position(), pick_word());
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    send_op(KIND_REMOVE, 8'sd0, '0);
    send_op(KIND_GET, -8'sd1, '0);
    send_op(KIND_NEXT, 8'sd0, '0);
    send_op(KIND_SET, 8'sd5, 32'hDEAD_BEEF);
    send_op(KIND_REWIND, 8'sd0, '0);
    send_op(KIND_SPARE_A, -8'sd128, '1);
    send_op(KIND_SPARE_B, 8'sd127, '1);
    send_op(KIND_INSERT, -8'sd128, 32'hFFFF_FFFF);
    send_op(KIND_INSERT, 8'sd127, 32'h0000_0000);
    send_op(KIND_INSERT, 8'sd1, 32'hA5A5_5A5A);
    send_op(KIND_GET, -8'sd128, '0);
    send_op(KIND_GET, 8'sd127, '0);
    send_op(KIND_GET, 8'sd1, '0);
    send_op(KIND_NEXT, 8'sd0, '0);
    send_op(KIND_INSERT, 8'sd0, 32'h1234_5678);
    send_op(KIND_NEXT, 8'sd0, '0);
    send_op(KIND_SET, 8'sd127, 32'h5555_AAAA);
    send_op(KIND_SET, -8'sd1, 32'hAAAA_5555);
    send_op(KIND_REMOVE, 8'sd2, '0);
    send_op(KIND_NEXT, 8'sd0, '0);
    send_op(KIND_NEXT, 8'sd0, '0);
    send_op(KIND_NEXT, 8'sd0, '0);
    send_op(KIND_REMOVE, -8'sd128, '0);
    send_op(KIND_REMOVE, 8'sd127, '0);
    send_op(KIND_REMOVE, 8'sd0, '0);
  endtask

  task automatic test_fill_to_capacity(bit idle);
    idle_on = idle;
    while (shadow_count < CAP) random_op(75, 5);
    repeat (3) send_op(KIND_INSERT, pick_position(), pick_word());
  endtask

  task automatic test_cursor_walk();
    idle_on = $urandom_range(0, 1);
    send_op(KIND_REWIND, pick_position(), pick_word());
    for (int i = 0; i < shadow_count + 2; i++) begin
      if ($urandom_range(0, 7) == 0) random_op(20, 20);
      else send_op(KIND_NEXT, pick_position(), pick_word());
    end
  endtask

  task automatic test_drain_to_empty(bit idle);
    idle_on = idle;
    while (shadow_count > 0) random_op(5, 70);
    repeat (2) random_op(0, 60);
  endtask

  task automatic test_mixed_churn(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) idle_on = $urandom_range(0, 2) != 0;
      if (shadow_count < 8) random_op(55, 10);
      else if (shadow_count > CAP - 8) random_op(10, 50);
      else random_op(30, 25);
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid) begin
      if (out_fault) faults_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected beat: word %h fault %b count %0d",
                 $time, out_read_word, out_fault, out_count_now);
        errors++;
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        if (out_read_word !== want.word) begin
          $display("%0t read_word mismatch: expected %h actual %h",
                   $time, want.word, out_read_word);
          errors++;
        end
        if (out_fault !== want.fault) begin
          $display("%0t fault mismatch: expected %b actual %b", $time, want.fault, out_fault);
          errors++;
        end
        if (out_count_now !== want.count) begin
          $display("%0t count_now mismatch: expected %0d actual %0d",
                   $time, want.count, out_count_now);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d beats outstanding", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_kind          = KIND_INSERT;
    in_position      = '0;
    in_entry_word    = '0;
    shadow_count     = 0;
    shadow_cursor    = 0;
    shadow_cursor_ok = 1'b0;
    errors           = 0;
    ops_sent         = 0;
    beats_checked    = 0;
    faults_seen      = 0;
    full_hits        = 0;
    idle_on          = 1'b0;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_fill_to_capacity(1'b1);
    test_cursor_walk();
    test_drain_to_empty(1'b1);
    test_mixed_churn(250);
    // closing stretch without idle gaps
    test_fill_to_capacity(1'b0);
    test_drain_to_empty(1'b0);

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("ran %0d list operations, %0d result beats checked, %0d faults",
             ops_sent, beats_checked, faults_seen);
    $display("inserts refused on a full list: %0d", full_hits);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
